// ----- rtl/pgrt_pkg.sv -----
// ----------------------------------------------------------------------------
// pgrt_pkg: shared types and constants for the pin group reservation table
// Table sizes, request and status codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pgrt_pkg;

  // Table geometry
  localparam int SLOTS       = 32;
  localparam int PIN_COUNT   = 64;
  localparam int KEY_LEN     = 8;
  localparam int MAX_RESULTS = 32;

  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int CNT_W    = $clog2(SLOTS + 1);
  localparam int LIST_CAP = (SLOTS < MAX_RESULTS) ? SLOTS : MAX_RESULTS;

  // Only the low PIN_COUNT pins and KEY_LEN key bytes are kept
  localparam logic [63:0] PIN_FIELD_MASK =
    (PIN_COUNT >= 64) ? {64{1'b1}} : ((64'd1 << PIN_COUNT) - 64'd1);
  localparam logic [63:0] KEY_FIELD_MASK =
    (KEY_LEN >= 8) ? {64{1'b1}} : ((64'd1 << (KEY_LEN * 8)) - 64'd1);

  typedef enum logic [1:0] {
    REQ_GRANT   = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_COUNT   = 2'd2,
    REQ_LIST    = 2'd3
  } req_kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_LEN   = 3'd1,
    ST_FULL      = 3'd2,
    ST_BUSY      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_TALLY,
    S_RESPOND
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;   // capture the input item
    logic match;  // register the per-slot overlap vector
    logic tally;  // register the overlap count
    logic reply;  // single result, table update
    logic emit;   // one list entry
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic list_go;   // list request with at least one entry to send
    logic list_last; // the entry about to go out is the last
  } dp_stat_t;

endpackage

// ----- rtl/pgrt_ctrl.sv -----
// ----------------------------------------------------------------------------
// pgrt_ctrl: sequencing controller
// Walks each item through match, tally and respond; stays in respond while
// a list streams one entry per cycle.
// ----------------------------------------------------------------------------
module pgrt_ctrl import pgrt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd,
  output logic      busy
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_MATCH;
        end
      end
      S_MATCH: begin
        cmd.match  = 1'b1;
        state_next = S_TALLY;
      end
      S_TALLY: begin
        cmd.tally  = 1'b1;
        state_next = S_RESPOND;
      end
      S_RESPOND: begin
        if (stat.list_go) begin
          cmd.emit = 1'b1;
          if (stat.list_last) begin
            state_next = S_IDLE;
          end
        end else begin
          cmd.reply  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/pgrt_datapath.sv -----
// ----------------------------------------------------------------------------
// pgrt_datapath: slot table, overlap compare and result register
// Holds the slot state, compares every slot against the mask in parallel,
// counts overlaps and forms the registered result transfer.
// ----------------------------------------------------------------------------
module pgrt_datapath import pgrt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  ctrl_cmd_t   cmd,
  output dp_stat_t    stat,
  input  logic [1:0]  req_type,
  input  logic [63:0] pin_mask,
  input  logic [4:0]  slot_handle,
  input  logic [63:0] owner_tag,
  input  logic [7:0]  tag_length,
  input  logic [5:0]  list_limit,
  output logic        strobe,
  output logic [2:0]  status,
  output logic [4:0]  granted_handle,
  output logic [5:0]  owner_count,
  output logic [63:0] entry_pins,
  output logic [63:0] entry_owner,
  output logic        entry_present,
  output logic        final_result
);

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] idx;
  } pick_t;

  // Lowest set bit of a slot vector
  function automatic pick_t first_set(input logic [SLOTS-1:0] v);
    pick_t p;
    p = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (v[i]) begin
        p.found = 1'b1;
        p.idx   = SLOT_W'(i);
      end
    end
    return p;
  endfunction

  // Slot table
  logic [SLOTS-1:0] slot_active;
  logic [63:0]      slot_pins  [SLOTS];
  logic [63:0]      slot_owner [SLOTS];
  logic [CNT_W-1:0] active_total;

  // Captured item
  req_kind_t        kind;
  logic [63:0]      mask_q;
  logic [4:0]       handle_q;
  logic [63:0]      tag_q;
  logic             len_ok;
  logic [CNT_W-1:0] cap;

  // Working registers
  logic [SLOTS-1:0] hits;
  logic [CNT_W-1:0] hit_count;
  logic [CNT_W-1:0] sent;

  logic [SLOTS-1:0] overlap;
  logic [CNT_W-1:0] list_n;
  pick_t            free_pick;
  pick_t            hit_pick;
  logic             handle_ok;
  logic [SLOT_W-1:0] rel_idx;

  // Per-slot overlap, all slots in parallel
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      overlap[i] = slot_active[i] && ((slot_pins[i] & mask_q) != 64'd0);
    end
  end

  assign list_n    = (hit_count < cap) ? hit_count : cap;
  assign free_pick = first_set(~slot_active);
  assign hit_pick  = first_set(hits);
  assign handle_ok = 32'(handle_q) < SLOTS;
  assign rel_idx   = SLOT_W'(handle_q);

  assign stat.list_go   = (kind == REQ_LIST) && (list_n != '0);
  assign stat.list_last = CNT_W'(sent + 1'b1) == list_n;

  // Item capture and working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind     <= req_kind_t'(req_type);
      mask_q   <= pin_mask & PIN_FIELD_MASK;
      handle_q <= slot_handle;
      tag_q    <= owner_tag & KEY_FIELD_MASK;
      len_ok   <= 32'(tag_length) == KEY_LEN;
      cap      <= (32'(list_limit) > LIST_CAP) ? CNT_W'(LIST_CAP) : CNT_W'(list_limit);
    end
    if (cmd.match) begin
      hits <= overlap;
    end
    if (cmd.tally) begin
      hit_count <= CNT_W'($countones(hits));
      sent      <= '0;
    end
    if (cmd.emit) begin
      hits[hit_pick.idx] <= 1'b0;
      sent               <= CNT_W'(sent + 1'b1);
    end
  end

  // Slot contents, written on a granted request
  always_ff @(posedge clk) begin
    if (cmd.reply && kind == REQ_GRANT && len_ok && 32'(active_total) < SLOTS
        && hits == '0 && free_pick.found) begin
      slot_pins[free_pick.idx]  <= mask_q;
      slot_owner[free_pick.idx] <= tag_q;
    end
  end

  // Active flags and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_active  <= '0;
      active_total <= '0;
    end else if (cmd.reply) begin
      if (kind == REQ_GRANT && len_ok && 32'(active_total) < SLOTS
          && hits == '0 && free_pick.found) begin
        slot_active[free_pick.idx] <= 1'b1;
        active_total               <= CNT_W'(active_total + 1'b1);
      end else if (kind == REQ_RELEASE && handle_ok && slot_active[rel_idx]) begin
        slot_active[rel_idx] <= 1'b0;
        if (active_total != '0) begin
          active_total <= CNT_W'(active_total - 1'b1);
        end
      end
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.reply | cmd.emit;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status         <= ST_OK;
      granted_handle <= 5'(hit_pick.idx);
      owner_count    <= 6'(list_n);
      entry_pins     <= slot_pins[hit_pick.idx];
      entry_owner    <= slot_owner[hit_pick.idx];
      entry_present  <= 1'b1;
      final_result   <= stat.list_last;
    end else if (cmd.reply) begin
      granted_handle <= '0;
      owner_count    <= '0;
      entry_pins     <= '0;
      entry_owner    <= '0;
      entry_present  <= 1'b0;
      final_result   <= 1'b1;
      unique case (kind)
        REQ_GRANT: begin
          priority if (!len_ok) begin
            status <= ST_BAD_LEN;
          end else if (32'(active_total) >= SLOTS) begin
            status <= ST_FULL;
          end else if (hits != '0) begin
            status <= ST_BUSY;
          end else if (!free_pick.found) begin
            status <= ST_FULL;
          end else begin
            status         <= ST_OK;
            granted_handle <= 5'(free_pick.idx);
          end
        end
        REQ_RELEASE: begin
          status <= (handle_ok && slot_active[rel_idx]) ? ST_OK : ST_NOT_FOUND;
        end
        REQ_COUNT: begin
          status      <= ST_OK;
          owner_count <= 6'(hit_count);
        end
        REQ_LIST: begin
          // list with nothing to send
          status <= ST_OK;
        end
        default: status <= ST_OK;
      endcase
    end
  end

endmodule

// ----- rtl/pin_group_reservation_table.sv -----
// ----------------------------------------------------------------------------
// pin_group_reservation_table: reservation table for groups of pins
// Grants, releases, counts and lists pin groups held in a table of slots.
//
//   Channel   Handshake            Payload
//   -------   ------------------   ----------------------------------------
//   command   start & !busy        req_type pin_mask slot_handle owner_tag
//                                  tag_length list_limit
//   result    strobe (one cycle)   status granted_handle owner_count
//                                  entry_pins entry_owner entry_present
//                                  final_result
//
// Each command passes through capture, slot compare and overlap count
// before its first result; a list then streams one entry per cycle, and
// busy stays high from the transfer until the last entry or the single
// result is formed.
// Results leave through an output register the cycle after they are formed,
// and the next command may be taken in that cycle. The receiver cannot stall.
// rst clears all slots to free; no clearing pass is needed.
// ----------------------------------------------------------------------------
module pin_group_reservation_table import pgrt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [63:0] pin_mask,
  input  logic [4:0]  slot_handle,
  input  logic [63:0] owner_tag,
  input  logic [7:0]  tag_length,
  input  logic [5:0]  list_limit,
  output logic        strobe,
  output logic [2:0]  status,
  output logic [4:0]  granted_handle,
  output logic [5:0]  owner_count,
  output logic [63:0] entry_pins,
  output logic [63:0] entry_owner,
  output logic        entry_present,
  output logic        final_result
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Sequencer
  pgrt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Table and result path
  pgrt_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .req_type       (req_type),
    .pin_mask       (pin_mask),
    .slot_handle    (slot_handle),
    .owner_tag      (owner_tag),
    .tag_length     (tag_length),
    .list_limit     (list_limit),
    .strobe         (strobe),
    .status         (status),
    .granted_handle (granted_handle),
    .owner_count    (owner_count),
    .entry_pins     (entry_pins),
    .entry_owner    (entry_owner),
    .entry_present  (entry_present),
    .final_result   (final_result)
  );

endmodule

// ----- test/pgrt_checker.sv -----
// ----------------------------------------------------------------------------
// pgrt_checker: result checker for the pin group reservation table
// Watches command and result transfers, keeps its own copy of the slot
// table, works out the replies each accepted command must produce and
// compares every strobed result with the oldest reply still due.
// ----------------------------------------------------------------------------
module pgrt_checker import pgrt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  req_type,
  input  logic [63:0] pin_mask,
  input  logic [4:0]  slot_handle,
  input  logic [63:0] owner_tag,
  input  logic [7:0]  tag_length,
  input  logic [5:0]  list_limit,
  input  logic        strobe,
  input  logic [2:0]  status,
  input  logic [4:0]  granted_handle,
  input  logic [5:0]  owner_count,
  input  logic [63:0] entry_pins,
  input  logic [63:0] entry_owner,
  input  logic        entry_present,
  input  logic        final_result,
  output int          mismatches,
  output int          awaited
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    status_t     st;
    logic [4:0]  slot;
    logic [5:0]  cnt;
    logic [63:0] pins;
    logic [63:0] owner;
    logic        present;
    logic        last;
  } reply_t;

  // Shadow of the slot table
  logic        held       [SLOTS];
  logic [63:0] held_pins  [SLOTS];
  logic [63:0] held_owner [SLOTS];
  int          held_total;

  reply_t due_replies[$];
  int     fails;

  function automatic reply_t make_reply(status_t st, int slot, int cnt,
                                        logic [63:0] pins, logic [63:0] owner,
                                        logic present, logic last);
    reply_t r;
    r.st      = st;
    r.slot    = 5'(slot);
    r.cnt     = 6'(cnt);
    r.pins    = pins;
    r.owner   = owner;
    r.present = present;
    r.last    = last;
    return r;
  endfunction

  function automatic logic overlaps(int i, logic [63:0] m);
    return held[i] && ((held_pins[i] & m) != 64'd0);
  endfunction

  // Update the shadow table for one command and queue the replies it causes
  task automatic apply_command(logic [1:0] kind, logic [63:0] mask_in,
                               logic [4:0] handle, logic [63:0] tag_in,
                               logic [7:0] tlen, logic [5:0] limit);
    logic [63:0] m;
    logic [63:0] tag;
    logic        clash;
    int          free_at;
    int          n;
    int          cap;
    int          k;
    m   = mask_in & PIN_FIELD_MASK;
    tag = tag_in & KEY_FIELD_MASK;
    case (req_kind_t'(kind))
      REQ_GRANT: begin
        // key length, then full table, then overlap
        if (int'(tlen) != KEY_LEN) begin
          due_replies.push_back(make_reply(ST_BAD_LEN, 0, 0, '0, '0, 1'b0, 1'b1));
        end else if (held_total >= SLOTS) begin
          due_replies.push_back(make_reply(ST_FULL, 0, 0, '0, '0, 1'b0, 1'b1));
        end else begin
          clash = 1'b0;
          for (int i = 0; i < SLOTS; i++) if (overlaps(i, m)) clash = 1'b1;
          free_at = -1;
          for (int i = SLOTS - 1; i >= 0; i--) if (!held[i]) free_at = i;
          if (clash) begin
            due_replies.push_back(make_reply(ST_BUSY, 0, 0, '0, '0, 1'b0, 1'b1));
          end else if (free_at < 0) begin
            due_replies.push_back(make_reply(ST_FULL, 0, 0, '0, '0, 1'b0, 1'b1));
          end else begin
            held[free_at]       = 1'b1;
            held_pins[free_at]  = m;
            held_owner[free_at] = tag;
            held_total++;
            due_replies.push_back(make_reply(ST_OK, free_at, 0, '0, '0, 1'b0, 1'b1));
          end
        end
      end
      REQ_RELEASE: begin
        // freed slot keeps its pins and key, only the active flag drops
        if (int'(handle) >= SLOTS || !held[handle]) begin
          due_replies.push_back(make_reply(ST_NOT_FOUND, 0, 0, '0, '0, 1'b0, 1'b1));
        end else begin
          held[handle] = 1'b0;
          if (held_total > 0) held_total--;
          due_replies.push_back(make_reply(ST_OK, 0, 0, '0, '0, 1'b0, 1'b1));
        end
      end
      REQ_COUNT: begin
        n = 0;
        for (int i = 0; i < SLOTS; i++) if (overlaps(i, m)) n++;
        due_replies.push_back(make_reply(ST_OK, 0, n, '0, '0, 1'b0, 1'b1));
      end
      default: begin
        // list: entries lowest slot first, truncated at the capped limit
        cap = (int'(limit) > LIST_CAP) ? LIST_CAP : int'(limit);
        n = 0;
        for (int i = 0; i < SLOTS; i++) if (n < cap && overlaps(i, m)) n++;
        if (n == 0) begin
          due_replies.push_back(make_reply(ST_OK, 0, 0, '0, '0, 1'b0, 1'b1));
        end else begin
          k = 0;
          for (int i = 0; i < SLOTS; i++) begin
            if (k < n && overlaps(i, m)) begin
              due_replies.push_back(make_reply(ST_OK, i, n, held_pins[i], held_owner[i],
                                               1'b1, (k + 1 == n)));
              k++;
            end
          end
        end
      end
    endcase
  endtask

  // Compare one result transfer against the oldest reply due
  task automatic check_reply();
    reply_t got;
    reply_t want;
    got = make_reply(status_t'(status), int'(granted_handle), int'(owner_count),
                     entry_pins, entry_owner, entry_present, final_result);
    if (due_replies.size() == 0) begin
      fails++;
      if (fails <= REPORT_LIMIT)
        $display("unexpected result: st=%0d slot=%0d cnt=%0d pins=%h owner=%h pres=%b last=%b",
                 status, granted_handle, owner_count, entry_pins, entry_owner,
                 entry_present, final_result);
    end else begin
      want = due_replies.pop_front();
      if (got.st !== want.st || got.slot !== want.slot || got.cnt !== want.cnt ||
          got.pins !== want.pins || got.owner !== want.owner ||
          got.present !== want.present || got.last !== want.last) begin
        fails++;
        if (fails <= REPORT_LIMIT) begin
          $display("mismatch: expected st=%0d slot=%0d cnt=%0d pins=%h owner=%h pres=%b last=%b",
                   want.st, want.slot, want.cnt, want.pins, want.owner,
                   want.present, want.last);
          $display("          actual   st=%0d slot=%0d cnt=%0d pins=%h owner=%h pres=%b last=%b",
                   status, granted_handle, owner_count, entry_pins, entry_owner,
                   entry_present, final_result);
        end
      end
    end
  endtask

  // Results are checked before a command taken at the same edge is applied
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        held[i]       = 1'b0;
        held_pins[i]  = '0;
        held_owner[i] = '0;
      end
      held_total = 0;
      due_replies.delete();
    end else begin
      if (strobe) check_reply();
      if (start && !busy)
        apply_command(req_type, pin_mask, slot_handle, owner_tag, tag_length, list_limit);
    end
    mismatches <= fails;
    awaited    <= due_replies.size();
  end

  initial fails = 0;

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: regression for the pin group reservation table
// A short directed sequence covers the status codes, freed slots and list
// truncation, then random episodes fill, churn, query and drain the table
// under three sender idling profiles. The checker beside the block judges
// every result; this module drives commands and reports the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import pgrt_pkg::*;

  localparam int RANDOM_ITEMS = 380;
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 20;

  typedef struct packed {
    req_kind_t   kind;
    logic [63:0] mask;
    logic [4:0]  handle;
    logic [63:0] tag;
    logic [7:0]  tlen;
    logic [5:0]  limit;
  } cmd_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  req_type = '0;
  logic [63:0] pin_mask = '0;
  logic [4:0]  slot_handle = '0;
  logic [63:0] owner_tag = '0;
  logic [7:0]  tag_length = '0;
  logic [5:0]  list_limit = '0;

  logic        busy;
  logic        strobe;
  logic [2:0]  status;
  logic [4:0]  granted_handle;
  logic [5:0]  owner_count;
  logic [63:0] entry_pins;
  logic [63:0] entry_owner;
  logic        entry_present;
  logic        final_result;

  int mismatches;
  int awaited;
  int quiet_cycles = 0;
  int issued = 0;
  int phase_seen = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  pin_group_reservation_table u_top (
    .clk, .rst, .start, .busy,
    .req_type, .pin_mask, .slot_handle, .owner_tag, .tag_length, .list_limit,
    .strobe, .status, .granted_handle, .owner_count,
    .entry_pins, .entry_owner, .entry_present, .final_result
  );

  pgrt_checker u_check (
    .clk, .rst, .start, .busy,
    .req_type, .pin_mask, .slot_handle, .owner_tag, .tag_length, .list_limit,
    .strobe, .status, .granted_handle, .owner_count,
    .entry_pins, .entry_owner, .entry_present, .final_result,
    .mismatches, .awaited
  );

  // Watchdog: cycles with neither a command nor a result transfer
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly one or two pins, sometimes none or a random spread
  function automatic logic [63:0] sparse_mask();
    case ($urandom_range(0, 9))
      0, 1:          return 64'd0;
      2, 3, 4, 5, 6: return 64'd1 << $urandom_range(0, 63);
      7, 8:          return (64'd1 << $urandom_range(0, 63)) | (64'd1 << $urandom_range(0, 63));
      default:       return rand64();
    endcase
  endfunction

  function automatic logic [63:0] wide_mask();
    if ($urandom_range(0, 3) == 0) return '1;
    return rand64();
  endfunction

  function automatic logic [7:0] pick_key_len();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'(KEY_LEN);
  endfunction

  function automatic logic [5:0] pick_limit();
    case ($urandom_range(0, 5))
      0:       return 6'd0;
      1:       return 6'd1;
      2:       return 6'd32;
      default: return 6'($urandom_range(0, 32));
    endcase
  endfunction

  // Unused fields carry random noise
  function automatic cmd_t noise();
    cmd_t c;
    c.kind   = req_kind_t'($urandom_range(0, 3));
    c.mask   = rand64();
    c.handle = 5'($urandom_range(0, 31));
    c.tag    = rand64();
    c.tlen   = 8'($urandom_range(0, 255));
    c.limit  = 6'($urandom_range(0, 32));
    return c;
  endfunction

  function automatic cmd_t mk_grant(logic [63:0] m, logic [63:0] t, logic [7:0] len);
    cmd_t c;
    c = noise();
    c.kind = REQ_GRANT;
    c.mask = m;
    c.tag  = t;
    c.tlen = len;
    return c;
  endfunction

  function automatic cmd_t mk_free(int h);
    cmd_t c;
    c = noise();
    c.kind   = REQ_RELEASE;
    c.handle = 5'(h);
    return c;
  endfunction

  function automatic cmd_t mk_count(logic [63:0] m);
    cmd_t c;
    c = noise();
    c.kind = REQ_COUNT;
    c.mask = m;
    return c;
  endfunction

  function automatic cmd_t mk_list(logic [63:0] m, logic [5:0] lim);
    cmd_t c;
    c = noise();
    c.kind  = REQ_LIST;
    c.mask  = m;
    c.limit = lim;
    return c;
  endfunction

  function automatic int idle_pct();
    if (issued < RANDOM_ITEMS / 3) return 6;
    if (issued < 2 * RANDOM_ITEMS / 3) return 62;
    return 0;
  endfunction

  // Present one command and hold it until the transfer happens
  task automatic issue(cmd_t c);
    while ($urandom_range(0, 99) < idle_pct()) begin
      start <= 1'b0;
      @(posedge clk);
    end
    req_type    <= c.kind;
    pin_mask    <= c.mask;
    slot_handle <= c.handle;
    owner_tag   <= c.tag;
    tag_length  <= c.tlen;
    list_limit  <= c.limit;
    start       <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // Hold off until every reply due has come back
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
  endtask

  // Random command; drains at each change of idling profile
  task automatic dispatch(cmd_t c);
    int phase;
    phase = issued * 3 / RANDOM_ITEMS;
    if (phase > 2) phase = 2;
    if (phase != phase_seen) begin
      settle();
      phase_seen = phase;
    end
    issue(c);
    issued++;
  endtask

  // Fill the table with disjoint pin pairs, then probe it
  task automatic fill_episode();
    int order[32];
    int n;
    int j;
    int tmp;
    for (int i = 0; i < 32; i++) order[i] = i;
    for (int i = 31; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    n = $urandom_range(28, 36);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 19) == 0)
        dispatch(mk_grant(64'h3 << (2 * order[k % 32]), rand64(), 8'($urandom_range(0, 255))));
      else if (k < 32)
        dispatch(mk_grant(64'h3 << (2 * order[k]), rand64(), 8'(KEY_LEN)));
      else
        dispatch(mk_grant(sparse_mask(), rand64(), 8'(KEY_LEN)));
    end
    dispatch(mk_grant(rand64(), rand64(), 8'($urandom_range(0, 255))));
    dispatch(mk_grant(64'd0, rand64(), 8'(KEY_LEN)));
    dispatch(mk_grant(wide_mask(), rand64(), 8'(KEY_LEN)));
  endtask

  task automatic churn_episode();
    int r;
    repeat (20) begin
      r = $urandom_range(0, 99);
      if (r < 40) dispatch(mk_grant(sparse_mask(), rand64(), pick_key_len()));
      else if (r < 70) dispatch(mk_free($urandom_range(0, 31)));
      else if (r < 85) dispatch(mk_count($urandom_range(0, 1) ? wide_mask() : sparse_mask()));
      else dispatch(mk_list(wide_mask(), pick_limit()));
    end
  endtask

  task automatic query_episode();
    logic [63:0] m;
    repeat (12) begin
      m = ($urandom_range(0, 3) == 0) ? sparse_mask() : wide_mask();
      if ($urandom_range(0, 1)) dispatch(mk_count(m));
      else dispatch(mk_list(m, pick_limit()));
    end
  endtask

  task automatic drain_episode();
    repeat ($urandom_range(20, 40)) dispatch(mk_free($urandom_range(0, 31)));
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, every status but full, freed slots, list truncation
    issue(mk_list('1, 6'd5));
    issue(mk_count('1));
    issue(mk_free(0));
    issue(mk_free(31));
    issue(mk_grant(rand64(), rand64(), 8'd0));
    issue(mk_grant(rand64(), rand64(), 8'd255));
    issue(mk_grant(rand64(), rand64(), 8'(KEY_LEN - 1)));
    issue(mk_grant(64'd0, '1, 8'(KEY_LEN)));
    issue(mk_grant('1, 64'd0, 8'(KEY_LEN)));
    issue(mk_grant(64'h8000_0000_0000_0000, rand64(), 8'(KEY_LEN)));
    issue(mk_count('1));
    issue(mk_list('1, 6'd32));
    issue(mk_list('1, 6'd0));
    issue(mk_count(64'd0));
    issue(mk_free(1));
    issue(mk_free(1));
    issue(mk_count('1));
    issue(mk_list('1, 6'd32));
    issue(mk_grant(64'h1, 64'h0123_4567_89ab_cdef, 8'(KEY_LEN)));
    issue(mk_grant(64'h2, 64'hfedc_ba98_7654_3210, 8'(KEY_LEN)));
    issue(mk_grant(64'h8000_0000_0000_0000, rand64(), 8'(KEY_LEN)));
    issue(mk_list('1, 6'd2));
    issue(mk_list('1, 6'd32));
    issue(mk_free(0));
    settle();

    // Random episodes
    while (issued < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1:       fill_episode();
        2, 3, 4, 5: churn_episode();
        6, 7:       query_episode();
        default:    drain_episode();
      endcase
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
